// ===== rtl/qslerp_pkg.sv =====
// Shared constants, types and the arctangent table of the quaternion slerp block.
`timescale 1ns / 1ps
`default_nettype none
package qslerp_pkg;

  localparam int unsigned FRAC_BITS        = 14;
  localparam int unsigned WORK_BITS        = 30;
  localparam int unsigned UP               = WORK_BITS - FRAC_BITS;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CW               = 36;
  localparam int unsigned RW               = 2 * WORK_BITS + 2;
  localparam int unsigned SQRT_STAGES      = WORK_BITS + 1;
  localparam int unsigned DIV_STAGES       = WORK_BITS + 2;
  localparam int unsigned DEN_W            = 34;
  localparam int unsigned WGT_W            = WORK_BITS + 2;
  localparam int unsigned PROD_W           = 51;

  localparam logic [14:0] NEAR_RESET = 15'd16382;
  localparam logic [14:0] ONE        = 15'(1 << FRAC_BITS);
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [14:0]      t;
    logic             slerp;
    logic             lin;
  } side_t;

  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] k);
    logic signed [CW-1:0] v;
    case (k)
      5'd0:    v = 36'sd843314857;
      5'd1:    v = 36'sd497837829;
      5'd2:    v = 36'sd263043837;
      5'd3:    v = 36'sd133525159;
      5'd4:    v = 36'sd67021687;
      5'd5:    v = 36'sd33543516;
      5'd6:    v = 36'sd16775851;
      5'd7:    v = 36'sd8388437;
      5'd8:    v = 36'sd4194283;
      5'd9:    v = 36'sd2097149;
      5'd10:   v = 36'sd1048576;
      5'd11:   v = 36'sd524288;
      5'd12:   v = 36'sd262144;
      5'd13:   v = 36'sd131072;
      5'd14:   v = 36'sd65536;
      5'd15:   v = 36'sd32768;
      5'd16:   v = 36'sd16384;
      5'd17:   v = 36'sd8192;
      5'd18:   v = 36'sd4096;
      5'd19:   v = 36'sd2048;
      5'd20:   v = 36'sd1024;
      5'd21:   v = 36'sd512;
      5'd22:   v = 36'sd256;
      5'd23:   v = 36'sd128;
      5'd24:   v = 36'sd64;
      5'd25:   v = 36'sd32;
      5'd26:   v = 36'sd16;
      5'd27:   v = 36'sd8;
      5'd28:   v = 36'sd4;
      5'd29:   v = 36'sd2;
      5'd30:   v = 36'sd1;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qslerp_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per stage; vectoring gives the angle, rotation the sine.
`timescale 1ns / 1ps
`default_nettype none
module qslerp_cordic #(
  parameter int unsigned STEPS  = qslerp_pkg::CORDIC_STEPS_DEF,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [qslerp_pkg::CW-1:0]  x_i,
  input  logic signed [qslerp_pkg::CW-1:0]  y_i,
  input  logic signed [qslerp_pkg::CW-1:0]  z_i,
  output logic signed [qslerp_pkg::CW-1:0]  res_o
);

  localparam int unsigned CW = qslerp_pkg::CW;

  logic signed [CW-1:0] x_q [STEPS];
  logic signed [CW-1:0] y_q [STEPS];
  logic signed [CW-1:0] z_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [CW-1:0] xs, ys, zs, dx, dy, ang;
    logic                 neg_dir;

    if (i == 0) begin : g_first
      assign xs = x_i;
      assign ys = y_i;
      assign zs = z_i;
    end else begin : g_next
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign zs = z_q[i-1];
    end

    assign dx  = ys >>> K;
    assign dy  = xs >>> K;
    assign ang = qslerp_pkg::atan_entry(K);
    // neg_dir: x -= dx, y += dy, z -= ang
    assign neg_dir = VECTOR ? (ys <= 0) : (zs >= 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (neg_dir) begin
          x_q[i] <= xs - dx;
          y_q[i] <= ys + dy;
          z_q[i] <= zs - ang;
        end else begin
          x_q[i] <= xs + dx;
          y_q[i] <= ys - dy;
          z_q[i] <= zs + ang;
        end
      end
    end
  end

  assign res_o = VECTOR ? z_q[STEPS-1] : y_q[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/qslerp_div.sv =====
// Pipelined restoring divider for the slerp weights, one quotient bit per stage, clamped to 2.0.
`timescale 1ns / 1ps
`default_nettype none
module qslerp_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [qslerp_pkg::DEN_W-1:0]        num_i,
  input  logic [qslerp_pkg::DEN_W-1:0]        den_i,
  output logic [qslerp_pkg::WGT_W-1:0]        q_o
);

  localparam int unsigned N     = qslerp_pkg::DIV_STAGES;
  localparam int unsigned DW    = qslerp_pkg::DEN_W;
  localparam int unsigned QW    = qslerp_pkg::WGT_W;
  localparam int unsigned WB    = qslerp_pkg::WORK_BITS;
  localparam int unsigned PB    = N - WB;
  localparam logic [QW-1:0] LIM = QW'(2) << WB;

  logic [DW-1:0] r_q   [N];
  logic [DW-1:0] den_q [N];
  logic [QW-1:0] q_q   [N];
  logic          ovf_q [N];
  logic [PB-1:0] lo_q  [N];

  // dividend is num << WB; its upper part starts as the remainder, the low
  // numerator bits are shifted in by the first stages
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [DW-1:0] rs, ds;
    logic [QW-1:0] qs;
    logic [PB-1:0] ls;
    logic          os, nb;
    logic [DW:0]   rin;

    if (s == 0) begin : g_first
      assign rs = num_i >> PB;
      assign ds = den_i;
      assign qs = '0;
      assign ls = num_i[PB-1:0];
      assign os = ({2'b00, num_i} >= {den_i, 2'b00});
    end else begin : g_next
      assign rs = r_q[s-1];
      assign ds = den_q[s-1];
      assign qs = q_q[s-1];
      assign ls = lo_q[s-1];
      assign os = ovf_q[s-1];
    end

    assign nb  = ls[PB-1];
    assign rin = {rs, nb};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= ds;
        ovf_q[s] <= os;
        lo_q[s]  <= ls << 1;
        if (rin >= {1'b0, ds}) begin
          r_q[s] <= DW'(rin - {1'b0, ds});
          q_q[s] <= {qs[QW-2:0], 1'b1};
        end else begin
          r_q[s] <= rin[DW-1:0];
          q_q[s] <= {qs[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = (ovf_q[N-1] || (q_q[N-1] > LIM)) ? LIM : q_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/quaternion_slerp_top.sv =====
// Quaternion slerp top level: dot product, sqrt, CORDIC acos and sines, divide, blend.
// From input transfer to output valid, data passes the 31-stage square root, two CORDIC
// pipelines in series (acos, then the sines) and the 32-stage divider.
// Throughput: one transfer per cycle; the whole pipeline holds while out_ready_i is low
// and the output register is full.
// Reset: rst_ni clears all valid bits and loads the near threshold thr_q with 16382.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_slerp_top #(
  parameter int unsigned CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] a_w_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] b_w_i,
  input  logic [14:0]        blend_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic signed [15:0] out_w_o
);

  localparam int unsigned FB  = qslerp_pkg::FRAC_BITS;
  localparam int unsigned WB  = qslerp_pkg::WORK_BITS;
  localparam int unsigned UP  = qslerp_pkg::UP;
  localparam int unsigned CW  = qslerp_pkg::CW;
  localparam int unsigned RW  = qslerp_pkg::RW;
  localparam int unsigned SQ  = qslerp_pkg::SQRT_STAGES;
  localparam int unsigned DVS = qslerp_pkg::DIV_STAGES;
  localparam int unsigned DW  = qslerp_pkg::DEN_W;
  localparam int unsigned QW  = qslerp_pkg::WGT_W;
  localparam int unsigned PW  = qslerp_pkg::PROD_W;

  localparam int unsigned S_SQ = 2 + SQ;
  localparam int unsigned S_AT = S_SQ + CORDIC_STEPS;
  localparam int unsigned M1   = S_AT + 1;
  localparam int unsigned M2   = M1 + 1;
  localparam int unsigned S_SN = M2 + CORDIC_STEPS;
  localparam int unsigned D0   = S_SN + 1;
  localparam int unsigned S_DV = D0 + DVS;
  localparam int unsigned F0   = S_DV + 1;
  localparam int unsigned F1   = F0 + 1;
  localparam int unsigned LAT  = F1 + 2;

  logic en;
  logic [14:0] thr_q;
  logic vld_q [LAT];
  qslerp_pkg::side_t side_q [LAT];
  qslerp_pkg::side_t side_d [LAT];

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qslerp_pkg::NEAR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage 1: component products
  logic signed [15:0] a_in [4];
  logic signed [15:0] b_in [4];
  logic signed [31:0] prod_q [4];

  assign a_in[0] = a_x_i;
  assign a_in[1] = a_y_i;
  assign a_in[2] = a_z_i;
  assign a_in[3] = a_w_i;
  assign b_in[0] = b_x_i;
  assign b_in[1] = b_y_i;
  assign b_in[2] = b_z_i;
  assign b_in[3] = b_w_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) prod_q[i] <= a_in[i] * b_in[i];
    end
  end

  // stage 2: rounded dot, sign fold
  logic signed [33:0] dot_sum, dot_rnd;
  logic signed [15:0] dot_sat;
  logic               dot_neg;
  logic [15:0]        dabs;
  logic [15:0]        d_q;

  always_comb begin
    dot_sum = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    dot_rnd = (dot_sum + (34'sd1 <<< (FB - 1))) >>> FB;
    if (dot_rnd > 34'sd32767) begin
      dot_sat = 16'sd32767;
    end else if (dot_rnd < -34'sd32768) begin
      dot_sat = -16'sd32768;
    end else begin
      dot_sat = dot_rnd[15:0];
    end
    dot_neg = dot_sat[15];
    dabs    = dot_neg ? 16'(-{dot_sat[15], dot_sat}) : dot_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) d_q <= dabs;
  end

  // stage 3: radicand 1 - d^2
  logic [14:0]           dc;
  logic [29:0]           dsq;
  logic [2*FB:0]         rem;
  logic [RW-1:0]         sq_n_q   [SQ+1];
  logic [RW-1:0]         sq_res_q [SQ+1];
  logic [WB:0]           sq_x_q   [SQ+1];

  always_comb begin
    dc  = (d_q > 16'(qslerp_pkg::ONE)) ? qslerp_pkg::ONE : d_q[14:0];
    dsq = dc * dc;
    rem = (2*FB+1)'((31'd1 << (2 * FB)) - 31'(dsq));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_n_q[0]   <= RW'(rem) << (2 * UP);
      sq_res_q[0] <= '0;
      sq_x_q[0]   <= (WB+1)'(dc) << UP;
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [RW-1:0] BITV = RW'(1) << (2 * (SQ - 1 - j));
    logic [RW-1:0] trial;
    assign trial = sq_res_q[j] + BITV;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_x_q[j+1] <= sq_x_q[j];
        if (sq_n_q[j] >= trial) begin
          sq_n_q[j+1]   <= sq_n_q[j] - trial;
          sq_res_q[j+1] <= (sq_res_q[j] >> 1) + BITV;
        end else begin
          sq_n_q[j+1]   <= sq_n_q[j];
          sq_res_q[j+1] <= sq_res_q[j] >> 1;
        end
      end
    end
  end

  // omega = atan(s / d)
  logic signed [CW-1:0] omega_raw;

  qslerp_cordic #(
    .STEPS  (CORDIC_STEPS),
    .VECTOR (1'b1)
  ) u_acos (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed(CW'(sq_x_q[SQ]))),
    .y_i   ($signed(CW'(sq_res_q[SQ]))),
    .z_i   ('0),
    .res_o (omega_raw)
  );

  // partial angles
  logic [31:0] om_q, om2_q, a0_q, a1_q;
  logic [46:0] a1p_q;
  logic [31:0] omega_c, a1_c;

  assign omega_c = omega_raw[CW-1] ? 32'd0 : omega_raw[31:0];
  assign a1_c    = 32'(a1p_q >> FB);

  always_ff @(posedge clk_i) begin
    if (en) begin
      om_q  <= omega_c;
      a1p_q <= 47'(side_q[M1-1].t) * 47'(omega_c);
      om2_q <= om_q;
      a1_q  <= a1_c;
      a0_q  <= om_q - a1_c;
    end
  end

  logic signed [CW-1:0] sin_w, sin_0, sin_1;

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_sin_w (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (qslerp_pkg::CORDIC_GAIN),
    .y_i   ('0),
    .z_i   ($signed({{(CW-32){1'b0}}, om2_q})),
    .res_o (sin_w)
  );

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_sin_0 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (qslerp_pkg::CORDIC_GAIN),
    .y_i   ('0),
    .z_i   ($signed({{(CW-32){1'b0}}, a0_q})),
    .res_o (sin_0)
  );

  qslerp_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_sin_1 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (qslerp_pkg::CORDIC_GAIN),
    .y_i   ('0),
    .z_i   ($signed({{(CW-32){1'b0}}, a1_q})),
    .res_o (sin_1)
  );

  // divider operands
  logic          sw_pos;
  logic [DW-1:0] num0_q, num1_q, den_q;
  logic [QW-1:0] q0, q1;

  assign sw_pos = (sin_w > 0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q <= sin_0[CW-1] ? '0 : sin_0[DW-1:0];
      num1_q <= sin_1[CW-1] ? '0 : sin_1[DW-1:0];
      den_q  <= sw_pos ? sin_w[DW-1:0] : DW'(1);
    end
  end

  qslerp_div u_div0 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num0_q),
    .den_i (den_q),
    .q_o   (q0)
  );

  qslerp_div u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num1_q),
    .den_i (den_q),
    .q_o   (q1)
  );

  // sideband transport
  always_comb begin
    side_d[0].t     = (blend_i > qslerp_pkg::ONE) ? qslerp_pkg::ONE : blend_i;
    side_d[0].slerp = 1'b0;
    side_d[0].lin   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      side_d[0].a[i] = a_in[i];
      side_d[0].b[i] = {b_in[i][15], b_in[i]};
    end
    for (int k = 1; k < LAT; k++) side_d[k] = side_q[k-1];
    for (int i = 0; i < 4; i++) begin
      side_d[1].b[i] = dot_neg ? 17'(-$signed(side_q[0].b[i])) : side_q[0].b[i];
    end
    side_d[1].slerp = ({1'b0, dabs} < {2'b00, thr_q});
    side_d[D0].lin  = !side_q[D0-1].slerp || !sw_pos;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LAT; k++) side_q[k] <= side_d[k];
    end
  end

  // weights and blend
  logic [QW-1:0]          w0_q, w1_q;
  logic signed [PW-1:0]   pa_q [4];
  logic signed [PW-1:0]   pb_q [4];
  logic signed [PW-1:0]   acc  [4];
  logic signed [PW-1:0]   rnd  [4];
  logic signed [15:0]     res  [4];
  logic signed [15:0]     out_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_q[F0-1].lin) begin
        w0_q <= QW'(qslerp_pkg::ONE - side_q[F0-1].t) << UP;
        w1_q <= QW'(side_q[F0-1].t) << UP;
      end else begin
        w0_q <= q0;
        w1_q <= q1;
      end
      for (int i = 0; i < 4; i++) begin
        pa_q[i] <= $signed(side_q[F1-1].a[i]) * $signed({1'b0, w0_q});
        pb_q[i] <= $signed(side_q[F1-1].b[i]) * $signed({1'b0, w1_q});
      end
      for (int i = 0; i < 4; i++) out_q[i] <= res[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = pa_q[i] + pb_q[i];
      rnd[i] = (acc[i] + (PW'(1) <<< (WB - 1))) >>> WB;
      if (rnd[i] > 51'sd32767) begin
        res[i] = 16'sd32767;
      end else if (rnd[i] < -51'sd32768) begin
        res[i] = -16'sd32768;
      end else begin
        res[i] = rnd[i][15:0];
      end
    end
  end

  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];
  assign out_w_o = out_q[3];

endmodule
`default_nettype wire
